@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/cmrr_pkg.sv @@
// ----------------------------------------------------------------------------
// cmrr_pkg
// Types, widths and sizes shared by the center of mass / RMS radius block.
// ----------------------------------------------------------------------------
package cmrr_pkg;

  localparam int MAX_BODIES = 256;
  localparam int ADDR_W     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  localparam int MASS_W = 12;
  localparam int POS_W  = 16;
  localparam int COM_W  = 16;
  localparam int RMS_W  = 17;

  // Running sums over at most 2**ADDR_W bodies.
  localparam int MASS_SUM_W = MASS_W + ADDR_W;
  localparam int MOM_W      = MASS_SUM_W + POS_W + 1;
  // Squared distance: two squares of a 16-bit magnitude.
  localparam int D2_W       = 2 * POS_W + 1;
  localparam int MUL_W      = D2_W + POS_W;
  localparam int SPREAD_W   = D2_W + MASS_W + ADDR_W;
  localparam int DIV_W      = (SPREAD_W > MOM_W) ? SPREAD_W : MOM_W;
  localparam int SQ_W       = 2 * RMS_W;

  typedef struct packed {
    logic [MASS_W-1:0]        body_mass;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     last_body;
  } body_t;

  typedef struct packed {
    logic signed [COM_W-1:0]  com_x;
    logic signed [COM_W-1:0]  com_y;
    logic [RMS_W-1:0]         radius;
    logic                     mass_positive;
    logic                     store_overflow;
  } result_t;

  typedef struct packed {
    logic [MASS_W-1:0]        mass;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hdl/cmrr_ram.sv @@
// ----------------------------------------------------------------------------
// cmrr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cmrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cmrr_div.sv @@
// ----------------------------------------------------------------------------
// cmrr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmrr_div
  import cmrr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [MASS_SUM_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [MASS_SUM_W-1:0] rem;
  logic [DIV_W-1:0]      quo;
  logic [CW-1:0]         cnt;
  logic                  running;

  logic [MASS_SUM_W:0]   trial;
  logic [MASS_SUM_W:0]   diff;
  logic                  fits;

  // The partial remainder stays below the divisor, so the trial value is
  // below twice the divisor and one subtraction settles each bit.
  assign trial = {rem, quo[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= '0;
        quo     <= dividend;
        cnt     <= CW'(DIV_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? diff[MASS_SUM_W-1:0] : trial[MASS_SUM_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/center_of_mass_rms_radius.sv @@
// ----------------------------------------------------------------------------
// center_of_mass_rms_radius
// A body that is not last is accepted and busy stays low: one per cycle.
// A last body raises busy through three passes of the bit-serial divider,
// the per-body states FETCH, LOAD, SQX, SQY, SUM, MUL, ACC on the shared
// multiplier and one root bit per cycle; a massless set ends at S_CHECK.
// The result strobe rises as busy falls. Reset clears the sums and count;
// the body store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module center_of_mass_rms_radius
  import cmrr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  body_t   body,
  output logic    busy,
  output logic    done,
  output result_t result
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIVX, S_DIVY, S_FETCH, S_LOAD, S_SQX, S_SQY,
    S_SUM, S_MUL, S_ACC, S_DIVS, S_ROOT
  } state_t;

  localparam int RCW = $clog2(RMS_W + 1);

  state_t state;

  logic [CNT_W-1:0]         body_count;
  logic [MASS_SUM_W-1:0]    mass_sum;
  logic signed [MOM_W-1:0]  moment_x_sum;
  logic signed [MOM_W-1:0]  moment_y_sum;
  logic [SPREAD_W-1:0]      spread_sum;
  logic                     overflow_seen;

  logic                     accept;
  logic                     store_we;
  entry_t                   wr_entry;
  entry_t                   rd_entry;
  logic [ADDR_W-1:0]        idx;

  logic signed [MASS_W+POS_W:0] mx_prod;
  logic signed [MASS_W+POS_W:0] my_prod;

  // Divider handshake and operand
  logic                     div_start;
  logic [DIV_W-1:0]         div_arg;
  logic                     div_neg;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic [COM_W-1:0]         quo_low;
  logic [COM_W-1:0]         com_val;

  logic [MOM_W-1:0]         mom_x_mag;
  logic [MOM_W-1:0]         mom_y_mag;

  // Second pass datapath
  logic [POS_W-1:0]         adx;
  logic [POS_W-1:0]         ady;
  logic [MASS_W-1:0]        bm;
  logic [D2_W-1:0]          d2;
  logic [MUL_W-1:0]         prod;
  logic [D2_W-1:0]          mul_a;
  logic [POS_W-1:0]         mul_b;
  logic signed [POS_W:0]    dx;
  logic signed [POS_W:0]    dy;
  logic [POS_W:0]           ndx;
  logic [POS_W:0]           ndy;

  // Square root
  logic [SQ_W-1:0]          rv;
  logic [SQ_W-1:0]          root;
  logic [SQ_W-1:0]          rbit;
  logic [RCW-1:0]           rcnt;
  logic [SQ_W:0]            rt_try;
  logic                     rt_fits;
  logic [SQ_W-1:0]          root_next;
  logic [SQ_W-1:0]          rv_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign store_we = accept && (body_count < CNT_W'(MAX_BODIES));

  assign wr_entry = {body.body_mass, body.pos_x, body.pos_y};

  assign mx_prod = $signed({1'b0, body.body_mass}) * body.pos_x;
  assign my_prod = $signed({1'b0, body.body_mass}) * body.pos_y;

  cmrr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BODIES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (body_count[ADDR_W-1:0]),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (rd_entry)
  );

  cmrr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_arg),
    .divisor  (mass_sum),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Moments are divided as magnitudes; the sign is put back on the quotient,
  // which gives truncation toward zero.
  assign mom_x_mag = moment_x_sum[MOM_W-1] ? MOM_W'(-moment_x_sum) : MOM_W'(moment_x_sum);
  assign mom_y_mag = moment_y_sum[MOM_W-1] ? MOM_W'(-moment_y_sum) : MOM_W'(moment_y_sum);
  assign quo_low   = div_quo[COM_W-1:0];
  assign com_val   = div_neg ? COM_W'(-quo_low) : quo_low;

  assign dx  = $signed({rd_entry.x[POS_W-1], rd_entry.x})
             - $signed({result.com_x[COM_W-1], result.com_x});
  assign dy  = $signed({rd_entry.y[POS_W-1], rd_entry.y})
             - $signed({result.com_y[COM_W-1], result.com_y});
  assign ndx = -dx;
  assign ndy = -dy;

  // Shared multiplier: both squares and the mass weighting go through it.
  always_comb begin
    case (state)
      S_SQX:   begin
        mul_a = D2_W'(adx);
        mul_b = adx;
      end
      S_SQY:   begin
        mul_a = D2_W'(ady);
        mul_b = ady;
      end
      S_MUL:   begin
        mul_a = d2;
        mul_b = POS_W'(bm);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rt_try    = {1'b0, root} + {1'b0, rbit};
  assign rt_fits   = ({1'b0, rv} >= rt_try);
  assign root_next = rt_fits ? ((root >> 1) + rbit) : (root >> 1);
  assign rv_next   = rt_fits ? (rv - rt_try[SQ_W-1:0]) : rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      div_start     <= 1'b0;
      body_count    <= '0;
      mass_sum      <= '0;
      moment_x_sum  <= '0;
      moment_y_sum  <= '0;
      spread_sum    <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      rcnt          <= '0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_we) begin
              body_count   <= body_count + CNT_W'(1);
              mass_sum     <= mass_sum + MASS_SUM_W'(body.body_mass);
              moment_x_sum <= moment_x_sum + MOM_W'(mx_prod);
              moment_y_sum <= moment_y_sum + MOM_W'(my_prod);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (body.last_body) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (mass_sum == '0) begin
            result.com_x          <= '0;
            result.com_y          <= '0;
            result.radius         <= '0;
            result.mass_positive  <= 1'b0;
            result.store_overflow <= overflow_seen;
            done                  <= 1'b1;
            body_count            <= '0;
            moment_x_sum          <= '0;
            moment_y_sum          <= '0;
            spread_sum            <= '0;
            overflow_seen         <= 1'b0;
            state                 <= S_IDLE;
          end else begin
            div_arg   <= DIV_W'(mom_x_mag);
            div_neg   <= moment_x_sum[MOM_W-1];
            div_start <= 1'b1;
            state     <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            result.com_x <= com_val;
            div_arg      <= DIV_W'(mom_y_mag);
            div_neg      <= moment_y_sum[MOM_W-1];
            div_start    <= 1'b1;
            state        <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            result.com_y <= com_val;
            idx          <= '0;
            spread_sum   <= '0;
            state        <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          adx   <= dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
          ady   <= dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
          bm    <= rd_entry.mass;
          state <= S_SQX;
        end
        S_SQX: begin
          prod  <= mul_a * mul_b;
          state <= S_SQY;
        end
        S_SQY: begin
          d2    <= prod[D2_W-1:0];
          prod  <= mul_a * mul_b;
          state <= S_SUM;
        end
        S_SUM: begin
          d2    <= d2 + prod[D2_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          spread_sum <= spread_sum + SPREAD_W'(prod);
          if (CNT_W'(idx) + CNT_W'(1) == body_count) begin
            state <= S_DIVS;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_FETCH;
          end
        end
        S_DIVS: begin
          // The spread sum is final in the cycle after the last accumulation.
          if (!div_start && !div_done && rcnt == '0) begin
            div_arg   <= DIV_W'(spread_sum);
            div_start <= 1'b1;
            rcnt      <= RCW'(RMS_W);
          end
          if (div_done) begin
            rv    <= div_quo[SQ_W-1:0];
            root  <= '0;
            rbit  <= SQ_W'(1) << (SQ_W - 2);
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          rv   <= rv_next;
          root <= root_next;
          rbit <= rbit >> 2;
          rcnt <= rcnt - RCW'(1);
          if (rcnt == RCW'(1)) begin
            result.radius         <= root_next[RMS_W-1:0];
            result.mass_positive  <= 1'b1;
            result.store_overflow <= overflow_seen;
            done                  <= 1'b1;
            body_count            <= '0;
            mass_sum              <= '0;
            moment_x_sum          <= '0;
            moment_y_sum          <= '0;
            spread_sum            <= '0;
            overflow_seen         <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // The mass sum is kept until the last division is done with it.
      if (state == S_CHECK && mass_sum == '0) begin
        mass_sum <= '0;
      end
    end
  end

  `ASSERT_IMPL(a_done_not_busy, clk, rst, done, !busy)
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, body_count <= CNT_W'(MAX_BODIES))
  `ASSERT_NEXT(a_last_goes_busy, clk, rst, accept && body.last_body, busy)
  `ASSERT_IMPL(a_div_in_div_state, clk, rst, div_done,
    state == S_DIVX || state == S_DIVY || state == S_DIVS)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: center of mass / RMS radius testbench
// Streams sets of 2D bodies into the block with bursty start timing, keeps a
// bit-true model of the sums, division and root, and compares every result
// strobe field by field against the model's queue of due results.
// ----------------------------------------------------------------------------
module tb;
  import cmrr_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_BODIES = 1300;
  localparam int DRAIN_CYCLES  = 100;
  localparam longint LIMIT_NS  = 64'd20_000_000;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  body_t   body  = '0;
  logic    busy;
  logic    done;
  result_t result;

  center_of_mass_rms_radius dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .body   (body),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #HALF_PERIOD clk = ~clk;

  body_t   bodies_to_send[$];
  result_t results_due[$];

  // Model of the set being collected.
  logic [MASS_W-1:0]       stored_mass[MAX_BODIES];
  logic signed [POS_W-1:0] stored_x[MAX_BODIES];
  logic signed [POS_W-1:0] stored_y[MAX_BODIES];
  int                      stored_count = 0;
  longint                  mass_total   = 0;
  longint                  moment_x     = 0;
  longint                  moment_y     = 0;
  logic                    bodies_dropped = 1'b0;

  int mismatches      = 0;
  int results_checked = 0;
  int bodies_sent     = 0;
  int overflow_sets   = 0;
  int massless_sets   = 0;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root;
  endfunction

  // Adds one transferred body to the model and, on the last body, queues the
  // expected center of mass and RMS radius.
  function automatic void absorb_body(body_t b);
    result_t         r;
    longint          cx;
    longint          cy;
    longint          dx;
    longint          dy;
    longint unsigned spread;
    longint unsigned d2;
    longint unsigned rms;
    if (stored_count < MAX_BODIES) begin
      stored_mass[stored_count] = b.body_mass;
      stored_x[stored_count]    = b.pos_x;
      stored_y[stored_count]    = b.pos_y;
      stored_count++;
      mass_total += longint'(b.body_mass);
      moment_x   += longint'(b.body_mass) * longint'(b.pos_x);
      moment_y   += longint'(b.body_mass) * longint'(b.pos_y);
    end else begin
      bodies_dropped = 1'b1;
    end
    if (!b.last_body) return;
    cx  = 0;
    cy  = 0;
    rms = 0;
    if (mass_total > 0) begin
      cx = moment_x / mass_total;
      cy = moment_y / mass_total;
      spread = 0;
      for (int i = 0; i < stored_count; i++) begin
        dx = longint'(stored_x[i]) - cx;
        dy = longint'(stored_y[i]) - cy;
        d2 = longint'(dx * dx + dy * dy);
        spread += longint'(stored_mass[i]) * d2;
      end
      rms = isqrt64(spread / mass_total);
    end
    r.com_x          = COM_W'(cx);
    r.com_y          = COM_W'(cy);
    r.radius         = RMS_W'(rms);
    r.mass_positive  = (mass_total > 0);
    r.store_overflow = bodies_dropped;
    results_due.push_back(r);
    stored_count   = 0;
    mass_total     = 0;
    moment_x       = 0;
    moment_y       = 0;
    bodies_dropped = 1'b0;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  task automatic push_body(int m, int x, int y, bit last);
    body_t b;
    b.body_mass = MASS_W'(m);
    b.pos_x     = POS_W'(x);
    b.pos_y     = POS_W'(y);
    b.last_body = last;
    bodies_to_send.push_back(b);
  endtask

  function automatic int pick_mass(bit massless);
    int sel;
    sel = $urandom_range(15);
    if (massless || sel == 0) return 0;
    if (sel == 1) return 4095;
    if (sel < 5) return $urandom_range(15);
    return $urandom_range(4095);
  endfunction

  function automatic int pick_coord(int center, int spread);
    int sel;
    int v;
    sel = $urandom_range(15);
    case (sel)
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(1) ? 0 : -1;
      default: ;
    endcase
    if (sel < 8) begin
      v = center + $urandom_range(2 * spread) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
    end
    return $urandom_range(65535) - 32768;
  endfunction

  // Queues one set of n bodies with random content; a few sets carry no mass.
  task automatic push_set(int n);
    bit massless;
    int cx;
    int cy;
    int spread;
    massless = ($urandom_range(19) == 0);
    cx       = $urandom_range(65535) - 32768;
    cy       = $urandom_range(65535) - 32768;
    spread   = 1 << $urandom_range(15);
    for (int i = 0; i < n; i++)
      push_body(pick_mass(massless), pick_coord(cx, spread), pick_coord(cy, spread), i == n - 1);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        absorb_body(body);
        bodies_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (bodies_to_send.size() > 0) begin
          body  <= bodies_to_send.pop_front();
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one result transfer.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result strobe", 1, 0);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (want.store_overflow) overflow_sets++;
        if (!want.mass_positive) massless_sets++;
        if (result.com_x !== want.com_x)
          report_mismatch("com_x", longint'(result.com_x), longint'(want.com_x));
        if (result.com_y !== want.com_y)
          report_mismatch("com_y", longint'(result.com_y), longint'(want.com_y));
        if (result.radius !== want.radius)
          report_mismatch("radius", longint'(result.radius), longint'(want.radius));
        if (result.mass_positive !== want.mass_positive)
          report_mismatch("mass_positive", longint'(result.mass_positive),
                          longint'(want.mass_positive));
        if (result.store_overflow !== want.store_overflow)
          report_mismatch("store_overflow", longint'(result.store_overflow),
                          longint'(want.store_overflow));
      end
    end
  end

  initial begin
    int queued;
    int sel;
    bit big_sets_done;
    // Directed sets: single bodies, opposite extremes, negative truncation,
    // massless sets and mixed zero-mass members.
    push_body(0, 32767, -32768, 1'b1);
    push_body(4095, -32768, -32768, 1'b1);
    push_body(4095, 32767, 32767, 1'b1);
    push_body(4095, 32767, 32767, 1'b0);
    push_body(4095, -32768, -32768, 1'b1);
    push_body(3, 256, -256, 1'b0);
    push_body(1, -257, 255, 1'b0);
    push_body(2, -1, 1, 1'b1);
    push_body(0, 100, 100, 1'b0);
    push_body(0, -5, 7, 1'b0);
    push_body(0, 32767, -32768, 1'b1);
    push_body(4095, 32767, -32768, 1'b0);
    push_body(1, -32768, 32767, 1'b0);
    push_body(0, 1234, -4321, 1'b1);
    push_body(1, 0, 0, 1'b0);
    push_body(4095, 1, -1, 1'b0);
    push_body(4095, -1, 1, 1'b0);
    push_body(1, 0, 0, 1'b1);
    push_body(2730, 21845, -21846, 1'b0);
    push_body(1365, -21846, 21845, 1'b1);

    // Random sets, mostly short; a full store and an overflowing one in the middle.
    queued        = 0;
    big_sets_done = 1'b0;
    while (queued < RANDOM_BODIES) begin
      if (!big_sets_done && queued >= 300) begin
        push_set(MAX_BODIES);
        push_set(MAX_BODIES + 4);
        queued += 2 * MAX_BODIES + 4;
        big_sets_done = 1'b1;
      end else begin
        sel = $urandom_range(19);
        if (sel < 16) begin
          sel = $urandom_range(1, 8);
        end else begin
          sel = $urandom_range(9, 40);
        end
        push_set(sel);
        queued += sel;
      end
    end

    @(negedge clk);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (bodies_to_send.size() != 0 || start || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bodies transferred, %0d results checked", bodies_sent, results_checked);
    $display("%0d sets overflowed the store, %0d sets had no mass", overflow_sets,
             massless_sets);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/cmrr_pkg.sv
hdl/cmrr_ram.sv
hdl/cmrr_div.sv
hdl/center_of_mass_rms_radius.sv
dv/tb.sv
